// ===== src/lmo_pkg.sv =====
// Shared types, constants and the exp2 fraction table of the logistic map oscillator.
// No dependencies; used by lmo_mul, lmo_div, the top level and the checker.
`default_nettype none

package lmo_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_PITCH_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_GROWTH_RATE   = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int CV_W       = 17;
    localparam int VOLTS_W    = 16;
    localparam int MAP_W      = 16;
    localparam int TIME_W     = 32;
    localparam int FRAC_W     = 12;
    localparam int IP_W       = 4;
    localparam int PHASE_W    = 16;

    // serial multiplier: 32 x 32 bits, one 8-bit digit of b per cycle
    localparam int MUL_W      = 32;
    localparam int MUL_DIGIT  = 8;
    localparam int MUL_STEPS  = MUL_W / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

    localparam int DIV_CNT_W  = $clog2(PHASE_W + 1);

    localparam logic signed [17:0] PITCH_LIMIT = 18'sd24576;
    localparam logic [31:0] ONE_Q30        = 32'd1073741824;
    localparam logic [31:0] HALF_C4        = 32'd8208233;
    localparam logic [5:0]  HP_SHIFT_BASE  = 6'd36;
    localparam logic [15:0] VOLTS_OFFSET   = 16'd24576;
    localparam logic [15:0] MAP_RESET      = 16'd32768;
    localparam logic [15:0] GROWTH_RESET   = 16'd52429;
    localparam logic [22:0] PERIOD_RESET   = 23'd97391;
    localparam logic [16:0] PHASE_ONE      = 17'h10000;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } t_div_req;

    // 2^(2^-(k+1)) in Q2.30
    function automatic logic [31:0] exp_tab(input logic [3:0] k);
        logic [31:0] v;
        unique case (k)
            4'd0:    v = 32'd1518500250;
            4'd1:    v = 32'd1276901417;
            4'd2:    v = 32'd1170923762;
            4'd3:    v = 32'd1121280436;
            4'd4:    v = 32'd1097253708;
            4'd5:    v = 32'd1085434106;
            4'd6:    v = 32'd1079572136;
            4'd7:    v = 32'd1076653033;
            4'd8:    v = 32'd1075196443;
            4'd9:    v = 32'd1074468887;
            4'd10:   v = 32'd1074105294;
            4'd11:   v = 32'd1073923544;
            4'd12:   v = 32'd1073832680;
            default: v = ONE_Q30;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/lmo_mul.sv =====
// Digit-serial unsigned multiplier, 32 x 32 -> 64 bits, one 8-bit digit of b per cycle.
// Depends on lmo_pkg for widths and the request struct.
`default_nettype none

module lmo_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lmo_pkg::t_mul_req           i_req,
    output logic                             o_done,
    output logic [2*lmo_pkg::MUL_W-1:0]      o_prod
);

    localparam int W = lmo_pkg::MUL_W;
    localparam int D = lmo_pkg::MUL_DIGIT;

    logic [W-1:0]                  r_a;
    logic [2*W-1:0]                r_p;
    logic [lmo_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_done;

    logic [W+D-1:0] w_pp;
    logic [W+D-1:0] w_sum;

    assign w_pp  = (W+D)'(r_a) * (W+D)'(r_p[D-1:0]);
    assign w_sum = (W+D)'(r_p[2*W-1:W]) + w_pp;

    // low half holds the unused digits of b, high half the running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_a    <= i_req.a;
            r_p    <= {{W{1'b0}}, i_req.b};
            r_cnt  <= lmo_pkg::MUL_CNT_W'(lmo_pkg::MUL_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_p    <= {w_sum, r_p[W-1:D]};
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == lmo_pkg::MUL_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

// ===== src/lmo_div.sv =====
// Bit-serial restoring divider for the blend phase: (num << 16) / den with num < den.
// Depends on lmo_pkg for widths and the request struct.
`default_nettype none

module lmo_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lmo_pkg::t_div_req             i_req,
    output logic                               o_done,
    output logic [lmo_pkg::PHASE_W-1:0]        o_quo
);

    localparam int W = lmo_pkg::TIME_W;
    localparam int Q = lmo_pkg::PHASE_W;

    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_den;
    logic [Q-1:0]                  r_quo;
    logic [lmo_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;

    logic [W:0] w_sh;
    logic [W:0] w_diff;
    logic       w_ge;

    assign w_sh   = {r_rem, 1'b0};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_cnt  <= lmo_pkg::DIV_CNT_W'(Q);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            // remainder stays below den, so the low bits are enough
            r_rem  <= w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
            r_quo  <= {r_quo[Q-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == lmo_pkg::DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== src/logistic_map_oscillator_core.sv =====
// Logistic map oscillator: sequencer, state and configuration registers.
// Depends on lmo_pkg, lmo_mul and lmo_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one pitch control voltage per
//   audio sample; output channel (o_out_valid / i_out_ready) returns one beat per
//   input beat with the output voltage and a flag that the map advanced.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   pitch offset, growth rate or sample period by index; unknown indexes drop.
//   Write configuration only while no sample is in flight.
// Timing:
//   One sample is processed at a time. Every product runs through one shared
//   multiplier: an issue step (dropped when issued at a hand-back), four 8-bit
//   digit steps and a hand-back. A sample needs 5 to 15 products depending on
//   the set bits of the pitch fraction and on whether the map steps, plus a
//   16-step bit-serial divide when the phase stays below one.
//   A new sample is accepted as soon as the sequencer is idle, even while the
//   previous result still waits in the output register; the sequencer holds
//   its finished result until the output register frees up.
// Reset: synchronous, active low. Registers return to their defaults, elapsed
//   time to zero, both map values to 0.5; no clearing pass is needed.
`default_nettype none

module logistic_map_oscillator_core #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lmo_pkg::CV_W-1:0]           i_pitch_cv,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [lmo_pkg::VOLTS_W-1:0]             o_out_volts,
    output logic                                    o_map_stepped,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lmo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lmo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int FW       = lmo_pkg::FRAC_W;
    localparam int EXP_LOOP = (EXP_TABLE_BITS < FW) ? EXP_TABLE_BITS : FW;
    localparam int RB       = FW - EXP_LOOP;
    localparam int KW       = $clog2(EXP_LOOP + 1);
    localparam logic [FW-1:0] REM_MASK  = FW'((1 << RB) - 1);
    localparam logic [31:0]   INT_SLOPE = lmo_pkg::exp_tab(4'(EXP_LOOP)) - lmo_pkg::ONE_Q30;

    typedef enum logic [4:0] {
        S_IDLE, S_EXP, S_EXP_WAIT, S_INT_ISSUE, S_INT_D, S_INT_ADD,
        S_HP_ISSUE, S_HP_WAIT, S_CMP, S_MAP_Q, S_MAP_X, S_PHASE,
        S_DIV_WAIT, S_BL_ISSUE, S_BL_A, S_BL_B, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_pitch_offset;
    logic [15:0] r_growth_rate;
    logic [22:0] r_sample_period;

    // oscillator state
    logic [31:0] r_elapsed;
    logic [15:0] r_prev;
    logic [15:0] r_cur;

    // per-sample work registers
    logic [lmo_pkg::IP_W-1:0] r_ip;
    logic [FW-1:0]            r_frac;
    logic [31:0]              r_m;
    logic [KW-1:0]            r_k;
    logic [31:0]              r_hp;
    logic [16:0]              r_l;
    logic [32:0]              r_acc;
    logic [15:0]              r_blend;
    logic                     r_stepped;

    // output register
    logic                           r_out_valid;
    logic [lmo_pkg::VOLTS_W-1:0]    r_out_volts;
    logic                           r_map_stepped;

    lmo_pkg::t_mul_req w_mul_req;
    lmo_pkg::t_div_req w_div_req;
    logic              w_mul_done;
    logic [63:0]       w_prod;
    logic              w_div_done;
    logic [15:0]       w_quo;

    lmo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    lmo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // pitch sum, clamp and split into octave and fraction
    logic signed [17:0] w_pitch_sum;
    logic signed [17:0] w_pitch;
    logic        [17:0] w_u;
    logic        [32:0] w_time_sum;
    logic        [31:0] w_time_sat;

    assign w_pitch_sum = $signed({{2{r_pitch_offset[15]}}, r_pitch_offset})
                       + $signed({i_pitch_cv[16], i_pitch_cv});

    always_comb begin
        priority if (w_pitch_sum > lmo_pkg::PITCH_LIMIT) begin
            w_pitch = lmo_pkg::PITCH_LIMIT;
        end else if (w_pitch_sum < -lmo_pkg::PITCH_LIMIT) begin
            w_pitch = -lmo_pkg::PITCH_LIMIT;
        end else begin
            w_pitch = w_pitch_sum;
        end
    end

    assign w_u        = 18'(lmo_pkg::PITCH_LIMIT - w_pitch);
    assign w_time_sum = {1'b0, r_elapsed} + 33'(r_sample_period);
    assign w_time_sat = w_time_sum[32] ? 32'hFFFF_FFFF : w_time_sum[31:0];

    // exp2 fraction loop
    logic [3:0]  w_fidx;
    logic        w_fbit;
    logic [FW-1:0] w_rem;
    logic [63:0] w_int_sh;

    assign w_fidx   = 4'(FW - 1) - 4'(r_k);
    assign w_fbit   = r_frac[w_fidx];
    assign w_rem    = r_frac & REM_MASK;
    assign w_int_sh = w_prod >> RB;

    // half period = (HALF_C4 * m) >> (36 - octave)
    logic [5:0]  w_hp_sh;
    logic [63:0] w_hp_full;
    logic [31:0] w_hp;

    assign w_hp_sh   = lmo_pkg::HP_SHIFT_BASE - 6'(r_ip);
    assign w_hp_full = w_prod >> w_hp_sh;
    assign w_hp      = (w_hp_full[31:0] == '0) ? 32'd1 : w_hp_full[31:0];

    logic w_due;
    assign w_due = (r_elapsed >= r_hp);

    // map step result, saturated
    logic [15:0] w_nx;
    assign w_nx = (w_prod[31:30] != 2'b00) ? 16'hFFFF : w_prod[29:14];

    // blend and volts
    logic [33:0] w_blend_sum;
    logic [19:0] w_b10;
    logic [15:0] w_volts;

    assign w_blend_sum = {1'b0, r_acc} + 34'(w_prod[32:0]);
    assign w_b10       = 20'({r_blend, 3'b000}) + 20'({r_blend, 1'b0});
    assign w_volts     = w_b10[19:4] - lmo_pkg::VOLTS_OFFSET;

    // multiplier and divider requests
    always_comb begin
        w_mul_req = '0;
        w_div_req = '0;
        unique case (r_state)
            S_EXP: begin
                if (r_k != KW'(EXP_LOOP) && w_fbit) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = r_m;
                    w_mul_req.b     = lmo_pkg::exp_tab(4'(r_k));
                end
            end
            S_INT_ISSUE: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = r_m;
                w_mul_req.b     = INT_SLOPE;
            end
            S_INT_D: begin
                w_mul_req.start = w_mul_done;
                w_mul_req.a     = w_prod[61:30];
                w_mul_req.b     = 32'(w_rem);
            end
            S_HP_ISSUE: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = r_m;
                w_mul_req.b     = lmo_pkg::HALF_C4;
            end
            S_CMP: begin
                w_mul_req.start = w_due;
                w_mul_req.a     = 32'(r_cur);
                w_mul_req.b     = 32'(lmo_pkg::PHASE_ONE - 17'(r_cur));
            end
            S_MAP_Q: begin
                w_mul_req.start = w_mul_done;
                w_mul_req.a     = 32'(r_growth_rate);
                w_mul_req.b     = 32'(w_prod[31:16]);
            end
            S_PHASE: begin
                w_div_req.start = !w_due;
                w_div_req.num   = r_elapsed;
                w_div_req.den   = r_hp;
            end
            S_BL_ISSUE: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = 32'(r_prev);
                w_mul_req.b     = 32'(lmo_pkg::PHASE_ONE - r_l);
            end
            S_BL_A: begin
                w_mul_req.start = w_mul_done;
                w_mul_req.a     = 32'(r_cur);
                w_mul_req.b     = 32'(r_l);
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_offset  <= '0;
            r_growth_rate   <= lmo_pkg::GROWTH_RESET;
            r_sample_period <= lmo_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lmo_pkg::CFG_PITCH_OFFSET:  r_pitch_offset  <= i_cfg_data[15:0];
                lmo_pkg::CFG_GROWTH_RATE:   r_growth_rate   <= i_cfg_data[15:0];
                lmo_pkg::CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_prev      <= lmo_pkg::MAP_RESET;
            r_cur       <= lmo_pkg::MAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ip      <= w_u[15:12];
                        r_frac    <= w_u[11:0];
                        r_m       <= lmo_pkg::ONE_Q30;
                        r_k       <= '0;
                        r_elapsed <= w_time_sat;
                        r_state   <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_k == KW'(EXP_LOOP)) begin
                        r_state <= (RB > 0) ? S_INT_ISSUE : S_HP_ISSUE;
                    end else if (w_fbit) begin
                        r_state <= S_EXP_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_EXP_WAIT: begin
                    if (w_mul_done) begin
                        r_m     <= w_prod[61:30];
                        r_k     <= r_k + 1'b1;
                        r_state <= S_EXP;
                    end
                end
                S_INT_ISSUE: begin
                    r_state <= S_INT_D;
                end
                S_INT_D: begin
                    if (w_mul_done) begin
                        r_state <= S_INT_ADD;
                    end
                end
                S_INT_ADD: begin
                    if (w_mul_done) begin
                        r_m     <= r_m + w_int_sh[31:0];
                        r_state <= S_HP_ISSUE;
                    end
                end
                S_HP_ISSUE: begin
                    r_state <= S_HP_WAIT;
                end
                S_HP_WAIT: begin
                    if (w_mul_done) begin
                        r_hp    <= w_hp;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_due) begin
                        r_elapsed <= r_elapsed - r_hp;
                        r_prev    <= r_cur;
                        r_stepped <= 1'b1;
                        r_state   <= S_MAP_Q;
                    end else begin
                        r_stepped <= 1'b0;
                        r_state   <= S_PHASE;
                    end
                end
                S_MAP_Q: begin
                    if (w_mul_done) begin
                        r_state <= S_MAP_X;
                    end
                end
                S_MAP_X: begin
                    if (w_mul_done) begin
                        r_cur   <= w_nx;
                        r_state <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    // still past the half period: phase clamps to one
                    if (w_due) begin
                        r_l     <= lmo_pkg::PHASE_ONE;
                        r_state <= S_BL_ISSUE;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_l     <= {1'b0, w_quo};
                        r_state <= S_BL_ISSUE;
                    end
                end
                S_BL_ISSUE: begin
                    r_state <= S_BL_A;
                end
                S_BL_A: begin
                    if (w_mul_done) begin
                        r_acc   <= w_prod[32:0];
                        r_state <= S_BL_B;
                    end
                end
                S_BL_B: begin
                    if (w_mul_done) begin
                        r_blend <= w_blend_sum[31:16];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until the output register frees up
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_volts   <= w_volts;
                        r_map_stepped <= r_stepped;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_volts   = r_out_volts;
    assign o_map_stepped = r_map_stepped;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

// ===== src/lmo_chk.sv =====
// Port-level checker for logistic_map_oscillator_core, attached by bind.
// Depends on lmo_pkg for port widths.
`default_nettype none

module lmo_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [lmo_pkg::VOLTS_W-1:0]       o_out_volts,
    input wire logic                              o_map_stepped
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_volts) && $stable(o_map_stepped))
        else $error("output payload changed while stalled");

    // one sample in flight: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second sample accepted while busy");

    // no result can appear the cycle after a sample is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared too early");

    a_volts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_volts) >= -16'sd24576)
                     && ($signed(o_out_volts) <= 16'sd16383))
        else $error("output voltage out of range");

endmodule

bind logistic_map_oscillator_core lmo_chk u_lmo_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_volts   (o_out_volts),
    .o_map_stepped (o_map_stepped)
);

`default_nettype wire
